### hdl/lcsld_pkg.sv
// ----------------------------------------------------------------------------
// lcsld_pkg
// Shared sizes, codes and types of the line diff core and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcsld_pkg;

  localparam int MAX_LINES  = 32;
  localparam int TOKEN_BITS = 32;
  localparam int LINE_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W      = $clog2(MAX_LINES + 1);
  localparam int SCORE_W    = CNT_W;
  localparam int STK_DEPTH  = 2 * MAX_LINES;
  localparam int STK_W      = $clog2(STK_DEPTH);
  localparam int SP_W       = $clog2(STK_DEPTH + 1);
  localparam int FILL_W     = CNT_W + 1;

  typedef enum logic [1:0] {
    OP_LOAD_OLD = 2'd0,
    OP_LOAD_NEW = 2'd1,
    OP_RUN      = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_SAME = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_DEL  = 2'd2
  } kind_t;

  typedef struct packed {
    logic                  valid;
    logic [LINE_W-1:0]     row;
    logic [TOKEN_BITS-1:0] tok;
    logic [SCORE_W-1:0]    score;
    logic [SCORE_W-1:0]    diag;
  } link_t;

  typedef struct packed {
    logic eq;
    logic add;
  } dir_t;

endpackage

`default_nettype wire

### hdl/lcs_line_diff_core.sv
// ----------------------------------------------------------------------------
// lcs_line_diff_core
// Line diff by longest common subsequence over a row of score cells.
// ----------------------------------------------------------------------------
// Command port: start with operation and line_token, taken when busy is low.
// Load old / load new store one token per cycle and never give a word; a load
// into a full side is dropped and shows on the overflow flag from the next run.
// Run: the old-side rows stream through the chain of column cells, each
// cell writing its column's match and direction bits. The backtrack then
// walks from the end; each edit takes a cell read, then a decision and a
// stack push. The script is sent from the edit stack in forward order, each
// word read from the stack and then sent, strobe high for one cycle per word
// and last on the final one. Counts and the drop flag clear after the final
// word, while overflow holds until the next run; a run with both sides empty
// gives no word. busy stays high from run until the counts clear.
// The receiver cannot stall: every word is taken in its strobe cycle.
// Reset clears counts, flag and control; stored tokens stay undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcs_line_diff_core import lcsld_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] line_token,
  output logic             strobe,
  output logic [1:0]       edit_kind,
  output logic [4:0]       line_index,
  output logic [31:0]      token_out,
  output logic             overflow,
  output logic             last
);

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_BT_RD, S_BT_DEC, S_EM_RD, S_EM_OUT
  } state_t;

  typedef struct packed {
    kind_t                 kind;
    logic [LINE_W-1:0]     idx;
    logic [TOKEN_BITS-1:0] tok;
  } stk_t;

  state_t                state;
  logic [CNT_W-1:0]      old_count;
  logic [CNT_W-1:0]      new_count;
  logic                  dropped;
  logic                  ovf;
  logic [FILL_W-1:0]     fill_t;
  logic [CNT_W-1:0]      bi;
  logic [CNT_W-1:0]      bj;
  logic [SP_W-1:0]       sp;
  logic [TOKEN_BITS-1:0] old_store [MAX_LINES];
  stk_t                  stk [STK_DEPTH];
  stk_t                  stk_rd;

  link_t                 link [MAX_LINES+1];
  logic [TOKEN_BITS-1:0] toks [MAX_LINES];
  dir_t                  dirs [MAX_LINES];

  logic                  accept;
  logic                  run_go;
  logic [TOKEN_BITS-1:0] in_tok;
  logic [CNT_W-1:0]      bi_m1;
  logic [CNT_W-1:0]      bj_m1;
  logic [SP_W-1:0]       sp_m1;
  logic [LINE_W-1:0]     old_addr;
  logic [TOKEN_BITS-1:0] old_tok;
  dir_t                  dir_sel;
  stk_t                  entry;
  logic                  step_i;
  logic                  step_j;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign run_go = accept && (operation == OP_RUN);
  assign in_tok = TOKEN_BITS'(line_token);
  assign bi_m1  = bi - 1'b1;
  assign bj_m1  = bj - 1'b1;
  assign sp_m1  = sp - 1'b1;

  assign old_addr = (state == S_FILL) ? fill_t[LINE_W-1:0] : bi_m1[LINE_W-1:0];
  assign old_tok  = old_store[old_addr];
  assign dir_sel  = dirs[bj_m1[LINE_W-1:0]];

  // column zero of the table
  always_comb begin
    link[0].valid = (state == S_FILL) && (fill_t < FILL_W'(old_count));
    link[0].row   = fill_t[LINE_W-1:0];
    link[0].tok   = old_tok;
    link[0].score = '0;
    link[0].diag  = '0;
  end

  for (genvar c = 0; c < MAX_LINES; c++) begin : g_cell
    lcsld_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (run_go),
      .load_en  (accept && (operation == OP_LOAD_NEW) && (new_count == CNT_W'(c))),
      .load_tok (in_tok),
      .link_in  (link[c]),
      .rd_row   (bi_m1[LINE_W-1:0]),
      .link_out (link[c+1]),
      .my_tok   (toks[c]),
      .rd_dir   (dirs[c])
    );
  end

  always_comb begin
    step_i = 1'b1;
    step_j = 1'b0;
    entry.kind = KIND_DEL;
    entry.idx  = bi_m1[LINE_W-1:0];
    entry.tok  = old_tok;
    if ((bi != '0) && (bj != '0) && dir_sel.eq) begin
      entry.kind = KIND_SAME;
      step_j     = 1'b1;
    end else if ((bj != '0) && ((bi == '0) || dir_sel.add)) begin
      entry.kind = KIND_ADD;
      entry.idx  = bj_m1[LINE_W-1:0];
      entry.tok  = toks[bj_m1[LINE_W-1:0]];
      step_i     = 1'b0;
      step_j     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (operation == OP_LOAD_OLD) && (old_count < CNT_W'(MAX_LINES))) begin
      old_store[old_count[LINE_W-1:0]] <= in_tok;
    end
    if (state == S_BT_DEC) begin
      stk[sp[STK_W-1:0]] <= entry;
    end
    stk_rd <= stk[sp_m1[STK_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      old_count <= '0;
      new_count <= '0;
      dropped   <= 1'b0;
      ovf       <= 1'b0;
      fill_t    <= '0;
      bi        <= '0;
      bj        <= '0;
      sp        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (operation)
              OP_LOAD_OLD: begin
                if (old_count < CNT_W'(MAX_LINES)) begin
                  old_count <= old_count + 1'b1;
                end else begin
                  dropped <= 1'b1;
                end
              end
              OP_LOAD_NEW: begin
                if (new_count < CNT_W'(MAX_LINES)) begin
                  new_count <= new_count + 1'b1;
                end else begin
                  dropped <= 1'b1;
                end
              end
              OP_RUN: begin
                ovf    <= dropped;
                fill_t <= '0;
                sp     <= '0;
                state  <= S_FILL;
              end
              default: begin
              end
            endcase
          end
        end
        S_FILL: begin
          fill_t <= fill_t + 1'b1;
          if (fill_t == FILL_W'(old_count) + FILL_W'(MAX_LINES - 1)) begin
            bi    <= old_count;
            bj    <= new_count;
            state <= S_BT_RD;
          end
        end
        S_BT_RD: begin
          if ((bi == '0) && (bj == '0)) begin
            if (sp == '0) begin
              old_count <= '0;
              new_count <= '0;
              dropped   <= 1'b0;
              state     <= S_IDLE;
            end else begin
              state <= S_EM_RD;
            end
          end else begin
            state <= S_BT_DEC;
          end
        end
        S_BT_DEC: begin
          sp <= sp + 1'b1;
          if (step_i) begin
            bi <= bi_m1;
          end
          if (step_j) begin
            bj <= bj_m1;
          end
          state <= S_BT_RD;
        end
        S_EM_RD: begin
          state <= S_EM_OUT;
        end
        S_EM_OUT: begin
          sp <= sp_m1;
          if (sp == SP_W'(1)) begin
            old_count <= '0;
            new_count <= '0;
            dropped   <= 1'b0;
            state     <= S_IDLE;
          end else begin
            state <= S_EM_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign strobe     = (state == S_EM_OUT);
  assign edit_kind  = stk_rd.kind;
  assign line_index = 5'(stk_rd.idx);
  assign token_out  = 32'(stk_rd.tok);
  assign overflow   = ovf;
  assign last       = (sp == SP_W'(1));

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy)
    else $error("final word did not end the run");

  a_word_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("words sent in consecutive cycles");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    run_go |=> busy && !strobe)
    else $error("run not taken up");

  a_counts_clear: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> (old_count == '0) && (new_count == '0) && !dropped)
    else $error("counts not cleared after script");

endmodule

`default_nettype wire

### hdl/lcsld_cell.sv
// ----------------------------------------------------------------------------
// lcsld_cell
// One column of the score wavefront: holds a new-side token and its column
// score, records the backtrack direction of every row it sees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcsld_cell import lcsld_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  clr,
  input  wire logic                  load_en,
  input  wire logic [TOKEN_BITS-1:0] load_tok,
  input  wire link_t                 link_in,
  input  wire logic [LINE_W-1:0]     rd_row,
  output link_t                      link_out,
  output logic [TOKEN_BITS-1:0]      my_tok,
  output dir_t                       rd_dir
);

  logic [SCORE_W-1:0] col_score;
  logic [SCORE_W-1:0] score_next;
  dir_t               dir_next;
  dir_t               col_mem [MAX_LINES];

  always_comb begin
    dir_next.eq  = (link_in.tok == my_tok);
    dir_next.add = (link_in.score >= col_score);
    if (dir_next.eq) begin
      score_next = SCORE_W'(link_in.diag + 1'b1);
    end else if (dir_next.add) begin
      score_next = link_in.score;
    end else begin
      score_next = col_score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
    end else begin
      link_out.valid <= link_in.valid;
    end
    link_out.row   <= link_in.row;
    link_out.tok   <= link_in.tok;
    link_out.score <= score_next;
    link_out.diag  <= col_score;
    if (load_en) begin
      my_tok <= load_tok;
    end
    if (clr) begin
      col_score <= '0;
    end else if (link_in.valid) begin
      col_score <= score_next;
    end
    if (link_in.valid) begin
      col_mem[link_in.row] <= dir_next;
    end
    rd_dir <= col_mem[rd_row];
  end

endmodule

`default_nettype wire

### bench/lcs_line_diff_core_test.sv
// ----------------------------------------------------------------------------
// lcs_line_diff_core_test
// Drives loads of old-side and new-side lines, unused opcodes and diff runs into
// the line diff core, predicts each edit script by an LCS table and backtrack of
// its own, and checks every edit word field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcs_line_diff_core_test;
  import lcsld_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  idx;
    logic [31:0] tok;
    logic        ovf;
    logic        lst;
  } edit_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operation = 2'd0;
  logic [31:0] line_token = 32'd0;
  logic        busy, strobe, overflow, last;
  logic [1:0]  edit_kind;
  logic [4:0]  line_index;
  logic [31:0] token_out;

  logic [31:0] old_lines [MAX_LINES];
  logic [31:0] new_lines [MAX_LINES];
  int unsigned n_old, n_new;
  bit          lines_dropped;
  edit_word_t  pending_edits [$];
  int          fail_count, word_count, run_count, item_count;

  lcs_line_diff_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .line_token(line_token), .strobe(strobe),
    .edit_kind(edit_kind), .line_index(line_index), .token_out(token_out),
    .overflow(overflow), .last(last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  // lcs table fill and backtrack, script pushed in forward order
  function automatic void predict_script();
    int unsigned score [MAX_LINES+1][MAX_LINES+1];
    edit_word_t  trail [$];
    edit_word_t  w;
    int unsigned i, j;
    for (i = 0; i <= n_old; i++)
      for (j = 0; j <= n_new; j++)
        if (i == 0 || j == 0) score[i][j] = 0;
        else if (old_lines[i-1] == new_lines[j-1]) score[i][j] = score[i-1][j-1] + 1;
        else score[i][j] = (score[i-1][j] > score[i][j-1]) ? score[i-1][j] : score[i][j-1];
    i = n_old;
    j = n_new;
    while (i > 0 || j > 0) begin
      w.ovf = lines_dropped;
      w.lst = 1'b0;
      if (i > 0 && j > 0 && old_lines[i-1] == new_lines[j-1]) begin
        w.kind = KIND_SAME; w.idx = 5'(i-1); w.tok = old_lines[i-1];
        i--; j--;
      end else if (j > 0 && (i == 0 || score[i][j-1] >= score[i-1][j])) begin
        w.kind = KIND_ADD; w.idx = 5'(j-1); w.tok = new_lines[j-1];
        j--;
      end else begin
        w.kind = KIND_DEL; w.idx = 5'(i-1); w.tok = old_lines[i-1];
        i--;
      end
      trail.push_front(w);
    end
    if (trail.size() > 0) trail[trail.size()-1].lst = 1'b1;
    foreach (trail[k]) pending_edits.push_back(trail[k]);
    n_old = 0;
    n_new = 0;
    lines_dropped = 0;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
        ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(input logic [1:0] op, input logic [31:0] tok,
                           input bit gaps = 1);
    if (gaps) idle_gap();
    start <= 1'b1;
    operation <= op;
    line_token <= tok;
    @(posedge clk);
    while (busy) @(posedge clk);
    item_count++;
    case (op)
      OP_LOAD_OLD: if (n_old < MAX_LINES) old_lines[n_old++] = tok; else lines_dropped = 1;
      OP_LOAD_NEW: if (n_new < MAX_LINES) new_lines[n_new++] = tok; else lines_dropped = 1;
      OP_RUN: begin
        predict_script();
        run_count++;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    edit_word_t e;
    if (!rst && strobe) begin
      word_count++;
      if (pending_edits.size() == 0) begin
        fail_count++;
        $display("%0t unexpected word kind %0d idx %0d tok %h", $time,
                 edit_kind, line_index, token_out);
      end else begin
        e = pending_edits.pop_front();
        if (e.kind !== edit_kind || e.idx !== line_index || e.tok !== token_out ||
            e.ovf !== overflow || e.lst !== last) begin
          fail_count++;
          $display("%0t mismatch exp k%0d i%0d t%h o%0d l%0d got k%0d i%0d t%h o%0d l%0d",
                   $time, e.kind, e.idx, e.tok, e.ovf, e.lst, edit_kind, line_index,
                   token_out, overflow, last);
        end
      end
    end
  end

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_edits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_edges();
    send_word(OP_RUN, 32'hFFFF_FFFF);
    send_word(2'd3, 32'h1234_5678);
    send_word(OP_LOAD_OLD, 32'h0000_0000);
    send_word(OP_LOAD_OLD, 32'hFFFF_FFFF);
    send_word(OP_LOAD_NEW, 32'hFFFF_FFFF);
    send_word(OP_LOAD_NEW, 32'hA5A5_5A5A);
    send_word(OP_RUN, 32'd0);
    send_word(OP_LOAD_OLD, 32'h0000_0001);
    send_word(OP_RUN, 32'd0);
    send_word(OP_LOAD_NEW, 32'h8000_0000);
    send_word(OP_RUN, 32'd0);
    wait_drained();
  endtask

  task automatic test_full_sides();
    for (int k = 0; k < MAX_LINES + 2; k++) send_word(OP_LOAD_OLD, $urandom_range(0, 3), 0);
    for (int k = 0; k < MAX_LINES + 1; k++) send_word(OP_LOAD_NEW, $urandom_range(0, 3), 0);
    send_word(OP_RUN, 32'd0);
    wait_drained();
  endtask

  // small alphabets give plenty of matches
  task automatic test_random_runs();
    int nl, nr, span;
    logic [31:0] base;
    while (item_count < 220) begin
      nl = $urandom_range(0, 8);
      nr = $urandom_range(0, 8);
      span = $urandom_range(1, 5);
      base = $urandom();
      for (int k = 0; k < nl + nr; k++) begin
        if ($urandom_range(0, 15) == 0) send_word(2'd3, $urandom());
        if ($urandom_range(0, 19) == 0)
          send_word(($urandom_range(0, 1) ? OP_LOAD_OLD : OP_LOAD_NEW), $urandom());
        else
          send_word((k < nl) ? OP_LOAD_OLD : OP_LOAD_NEW, base ^ $urandom_range(0, span));
      end
      send_word(OP_RUN, $urandom());
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    n_old = 0; n_new = 0; lines_dropped = 0;
    fail_count = 0; word_count = 0; run_count = 0; item_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_full_sides();
    test_random_runs();
    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d diff runs, %0d edit words checked",
             item_count, run_count, word_count);
    $display("covered empty sides, full sides with drops, bad opcodes, random scripts");
    if (fail_count == 0 && pending_edits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### files.f
hdl/lcsld_pkg.sv
hdl/lcsld_cell.sv
hdl/lcs_line_diff_core.sv
bench/lcs_line_diff_core_test.sv
